[sv/row_set_containment_check_assert.svh]
// Assertion macros shared by the row set containment checker.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ROW_SET_CONTAINMENT_CHECK_ASSERT_SVH
`define ROW_SET_CONTAINMENT_CHECK_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define RSCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define RSCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/rscc_pkg.sv]
package rscc_pkg;

    localparam int ELEM_W         = 32;
    localparam int IN_ELEMS       = 4;
    localparam int ROW_INDEX_W    = 4;
    localparam int ROW_COUNT_W    = 5;
    localparam int OPCODE_W       = 2;
    localparam int RELATION_W     = 2;
    localparam int MAX_ROWS_DEF   = 16;
    localparam int ROW_LENGTH_DEF = 4;

    localparam int ROW_INDEX_LSB  = 0;
    localparam int ELEMS_LSB      = ROW_INDEX_LSB + ROW_INDEX_W;
    localparam int ROWS_A_LSB     = ELEMS_LSB + IN_ELEMS * ELEM_W;
    localparam int ROWS_B_LSB     = ROWS_A_LSB + ROW_COUNT_W;
    localparam int S_FIELDS_W     = ROWS_B_LSB + ROW_COUNT_W;
    localparam int S_TDATA_W      = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W      = ((RELATION_W + 7) / 8) * 8;

    localparam logic [OPCODE_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_EVAL   = 2'd2;

    localparam logic [RELATION_W-1:0] REL_NONE   = 2'd0;
    localparam logic [RELATION_W-1:0] REL_A_IN_B = 2'd1;
    localparam logic [RELATION_W-1:0] REL_B_IN_A = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_START  = 4'b0010,
        S_RUN    = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

endpackage

[sv/rscc_lane.sv]
module rscc_lane
    import rscc_pkg::*;
#(
    parameter int ROW_LENGTH = ROW_LENGTH_DEF
)
(
    input  logic [ELEM_W-1:0]            p_elem,
    input  logic [ROW_LENGTH*ELEM_W-1:0] q_row,
    output logic [ROW_LENGTH-1:0]        eq,
    output logic [ROW_LENGTH-1:0]        ge
);

    always_comb
    begin
        for (int k = 0; k < ROW_LENGTH; k++)
        begin
            eq[k] = q_row[k*ELEM_W +: ELEM_W] == p_elem;
            ge[k] = $signed(q_row[k*ELEM_W +: ELEM_W]) >= $signed(p_elem);
        end
    end

endmodule

[sv/rscc_merge.sv]
module rscc_merge
    import rscc_pkg::*;
#(
    parameter int ROW_LENGTH = ROW_LENGTH_DEF
)
(
    input  logic [ROW_LENGTH-1:0][ROW_LENGTH-1:0] eq,
    input  logic [ROW_LENGTH-1:0][ROW_LENGTH-1:0] ge,
    output logic                                  contained
);

    logic [ROW_LENGTH-1:0] avail;
    logic [ROW_LENGTH-1:0] cand;
    logic [ROW_LENGTH-1:0] pick;

    // Each element of p takes the first q position at or after the previous
    // one whose value is not below it; that value must then be equal.
    always_comb
    begin
        contained = 1'b1;
        avail     = '1;
        cand      = '0;
        pick      = '0;
        for (int i = 0; i < ROW_LENGTH; i++)
        begin
            cand      = ge[i] & avail;
            pick      = cand & (~cand + 1'b1);
            contained = contained & (|(pick & eq[i]));
            avail     = ~(pick - 1'b1);
        end
    end

endmodule

[sv/row_set_containment_check.sv]
// Channel   Dir  tuser            tdata
// s_axis    in   opcode           row_index, elem0..elem3, rows_a, rows_b
// m_axis    out  none             relation
//
// A load beat writes one row of A or B.
// An evaluate beat, per direction, starts, then takes each row of one set in
// turn and scans the rows of the other for one that contains it; the result
// is then presented. Each row memory has a single read port, and together
// they supply one row pair a cycle, though a hit discards the pair behind it.
// Reset clears only control state; row memories hold garbage until loaded.
// No beat is taken during an evaluation, and a finished result waits in the
// output register while loads continue.
module row_set_containment_check
    import rscc_pkg::*;
#(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int ROW_LENGTH = ROW_LENGTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: row_index, elem0, elem1, elem2, elem3, rows_a, rows_b.
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: opcode.
    input  logic [OPCODE_W-1:0]   s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: relation.
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int CMP_W = (CNT_W > ROW_COUNT_W) ? CNT_W : ROW_COUNT_W;
    localparam int ROW_W = ROW_LENGTH * ELEM_W;

    logic [ROW_W-1:0] mem_a [MAX_ROWS];
    logic [ROW_W-1:0] mem_b [MAX_ROWS];

    state_t                state_reg, state_next;
    logic                  dir_reg, dir_next;
    logic [CNT_W-1:0]      na_reg, na_next;
    logic [CNT_W-1:0]      nb_reg, nb_next;
    logic [CNT_W-1:0]      ir_reg, ir_next;
    logic [CNT_W-1:0]      is_reg, is_next;
    logic                  pipe_valid_reg, pipe_valid_next;
    logic                  pipe_last_reg, pipe_last_next;
    logic [RELATION_W-1:0] rel_reg, rel_next;
    logic                  m_valid_reg, m_valid_next;
    logic [RELATION_W-1:0] m_rel_reg, m_rel_next;
    logic [ROW_W-1:0]      a_rd_reg;
    logic [ROW_W-1:0]      b_rd_reg;

    logic                  s_accept;
    logic                  in_range;
    logic                  wr_a;
    logic                  wr_b;
    logic [CMP_W-1:0]      idx_ext;
    logic [CMP_W-1:0]      rows_a_ext;
    logic [CMP_W-1:0]      rows_b_ext;
    logic [CNT_W-1:0]      na_sat;
    logic [CNT_W-1:0]      nb_sat;
    logic [ROW_W-1:0]      in_row;
    logic [IDX_W-1:0]      rd_addr_a;
    logic [IDX_W-1:0]      rd_addr_b;
    logic [CNT_W-1:0]      cur_nx;
    logic [CNT_W-1:0]      cur_ny;
    logic                  issue_en;
    logic                  dir_pass;
    logic                  dir_fail;
    logic                  out_free;
    logic [ROW_W-1:0]      x_row;
    logic [ROW_W-1:0]      y_row;
    logic [ROW_LENGTH-1:0][ROW_LENGTH-1:0] lane_eq;
    logic [ROW_LENGTH-1:0][ROW_LENGTH-1:0] lane_ge;
    logic                  hit;

    assign s_axis_tready = state_reg == S_IDLE;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(m_rel_reg);

    assign idx_ext    = CMP_W'(s_axis_tdata[ROW_INDEX_LSB +: ROW_INDEX_W]);
    assign rows_a_ext = CMP_W'(s_axis_tdata[ROWS_A_LSB +: ROW_COUNT_W]);
    assign rows_b_ext = CMP_W'(s_axis_tdata[ROWS_B_LSB +: ROW_COUNT_W]);
    assign in_range   = idx_ext < CMP_W'(MAX_ROWS);
    assign na_sat = (rows_a_ext > CMP_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_a_ext[CNT_W-1:0];
    assign nb_sat = (rows_b_ext > CMP_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_b_ext[CNT_W-1:0];

    assign wr_a = s_accept && (s_axis_tuser == OP_LOAD_A) && in_range;
    assign wr_b = s_accept && (s_axis_tuser == OP_LOAD_B) && in_range;

    // Values past the four carried by a beat are stored as zero.
    always_comb
    begin
        in_row = '0;
        for (int e = 0; e < ROW_LENGTH; e++)
        begin
            if (e < IN_ELEMS)
            begin
                in_row[e*ELEM_W +: ELEM_W] = s_axis_tdata[ELEMS_LSB + e*ELEM_W +: ELEM_W];
            end
        end
    end

    assign rd_addr_a = dir_reg ? is_reg[IDX_W-1:0] : ir_reg[IDX_W-1:0];
    assign rd_addr_b = dir_reg ? ir_reg[IDX_W-1:0] : is_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[idx_ext[IDX_W-1:0]] <= in_row;
        end
        a_rd_reg <= mem_a[rd_addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            mem_b[idx_ext[IDX_W-1:0]] <= in_row;
        end
        b_rd_reg <= mem_b[rd_addr_b];
    end

    assign x_row = dir_reg ? b_rd_reg : a_rd_reg;
    assign y_row = dir_reg ? a_rd_reg : b_rd_reg;

    for (genvar i = 0; i < ROW_LENGTH; i++)
    begin : g_lane
        rscc_lane #(
            .ROW_LENGTH (ROW_LENGTH)
        ) u_lane (
            .p_elem (x_row[i*ELEM_W +: ELEM_W]),
            .q_row  (y_row),
            .eq     (lane_eq[i]),
            .ge     (lane_ge[i])
        );
    end

    rscc_merge #(
        .ROW_LENGTH (ROW_LENGTH)
    ) u_merge (
        .eq        (lane_eq),
        .ge        (lane_ge),
        .contained (hit)
    );

    assign cur_nx   = dir_reg ? nb_reg : na_reg;
    assign cur_ny   = dir_reg ? na_reg : nb_reg;
    assign issue_en = (state_reg == S_RUN) && (is_reg < cur_ny);
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next      = state_reg;
        dir_next        = dir_reg;
        na_next         = na_reg;
        nb_next         = nb_reg;
        ir_next         = ir_reg;
        is_next         = is_reg;
        pipe_valid_next = 1'b0;
        pipe_last_next  = 1'b0;
        rel_next        = rel_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_rel_next      = m_rel_reg;
        dir_pass        = 1'b0;
        dir_fail        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept && (s_axis_tuser == OP_EVAL))
                begin
                    na_next    = na_sat;
                    nb_next    = nb_sat;
                    dir_next   = 1'b0;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                ir_next = '0;
                is_next = '0;
                if (cur_nx == '0)
                begin
                    dir_pass = 1'b1;
                end
                else if (cur_ny == '0)
                begin
                    dir_fail = 1'b1;
                end
                else
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (issue_en)
                begin
                    is_next         = is_reg + 1'b1;
                    pipe_valid_next = 1'b1;
                    pipe_last_next  = is_reg == (cur_ny - 1'b1);
                end
                if (pipe_valid_reg)
                begin
                    if (hit)
                    begin
                        pipe_valid_next = 1'b0;
                        if ((ir_reg + 1'b1) == cur_nx)
                        begin
                            dir_pass = 1'b1;
                        end
                        else
                        begin
                            ir_next = ir_reg + 1'b1;
                            is_next = '0;
                        end
                    end
                    else if (pipe_last_reg)
                    begin
                        dir_fail = 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_rel_next   = rel_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (dir_pass)
        begin
            pipe_valid_next = 1'b0;
            rel_next        = dir_reg ? REL_B_IN_A : REL_A_IN_B;
            state_next      = S_FINISH;
        end
        else if (dir_fail)
        begin
            pipe_valid_next = 1'b0;
            if (dir_reg)
            begin
                rel_next   = REL_NONE;
                state_next = S_FINISH;
            end
            else
            begin
                dir_next   = 1'b1;
                state_next = S_START;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pipe_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pipe_valid_reg <= pipe_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg       <= dir_next;
        na_reg        <= na_next;
        nb_reg        <= nb_next;
        ir_reg        <= ir_next;
        is_reg        <= is_next;
        pipe_last_reg <= pipe_last_next;
        rel_reg       <= rel_next;
        m_rel_reg     <= m_rel_next;
    end

`include "row_set_containment_check_assert.svh"

    `RSCC_ASSERT_NOW(a_idle_no_flight, s_axis_tready, !pipe_valid_reg, "row pair in flight while idle")
    `RSCC_ASSERT_NOW(a_flight_in_run, pipe_valid_reg, state_reg == S_RUN, "row pair outside run")
    `RSCC_ASSERT_NOW(a_row_bound, state_reg == S_RUN, ir_reg < cur_nx, "row pointer past count")
    `RSCC_ASSERT_NEXT(a_eval_starts, s_accept && (s_axis_tuser == OP_EVAL), state_reg == S_START, "evaluate did not start")
    `RSCC_ASSERT_NEXT(a_finish_out, (state_reg == S_FINISH) && out_free, m_axis_tvalid && s_axis_tready, "finished result not presented")

endmodule

[dv/relation_checker.sv]
module relation_checker
    import rscc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // Fields from bit 0: row_index, elem0, elem1, elem2, elem3, rows_a, rows_b.
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: opcode.
    input  logic [OPCODE_W-1:0]   s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: relation.
    input  logic [M_TDATA_W-1:0]  m_axis_tdata,
    output int                    fail_count,
    output int                    outstanding,
    output int                    results_seen
);

    typedef logic [IN_ELEMS-1:0][ELEM_W-1:0] row_word_t;

    row_word_t             rows_a_mem [MAX_ROWS_DEF];
    row_word_t             rows_b_mem [MAX_ROWS_DEF];
    logic [RELATION_W-1:0] relation_q [$];
    logic [RELATION_W-1:0] expected_rel;
    logic [RELATION_W-1:0] actual_rel;
    int                    fails;
    int                    seen;

    function automatic logic row_in_row(row_word_t p, row_word_t q);
        int i;
        int k;
        i = 0;
        k = 0;
        while (i < IN_ELEMS && k < IN_ELEMS)
        begin
            if (p[i] == q[k])
                i++;
            else if ($signed(p[i]) < $signed(q[k]))
                return 1'b0;
            else
                k++;
        end
        return i == IN_ELEMS;
    endfunction

    function automatic logic covers(logic a_over_b, int nx, int ny);
        logic      found;
        row_word_t p;
        row_word_t q;
        for (int r = 0; r < nx; r++)
        begin
            found = 1'b0;
            for (int s = 0; s < ny && !found; s++)
            begin
                p = a_over_b ? rows_a_mem[r] : rows_b_mem[r];
                q = a_over_b ? rows_b_mem[s] : rows_a_mem[s];
                if (row_in_row(p, q))
                    found = 1'b1;
            end
            if (!found)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [RELATION_W-1:0] predict_relation(int na, int nb);
        if (na > MAX_ROWS_DEF)
            na = MAX_ROWS_DEF;
        if (nb > MAX_ROWS_DEF)
            nb = MAX_ROWS_DEF;
        if (covers(1'b1, na, nb))
            return REL_A_IN_B;
        else if (covers(1'b0, nb, na))
            return REL_B_IN_A;
        return REL_NONE;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relation_q.delete();
            fails = 0;
            seen = 0;
            fail_count <= 0;
            outstanding <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                actual_rel = m_axis_tdata[RELATION_W-1:0];
                seen++;
                if (relation_q.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result beat, expected none, actual relation %0d",
                             $time, actual_rel);
                end
                else
                begin
                    expected_rel = relation_q.pop_front();
                    if (actual_rel !== expected_rel)
                    begin
                        fails++;
                        $display("%0t: relation mismatch, expected %0d, actual %0d",
                                 $time, expected_rel, actual_rel);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                case (s_axis_tuser)
                    OP_LOAD_A:
                        rows_a_mem[s_axis_tdata[ROW_INDEX_LSB +: ROW_INDEX_W]] =
                            s_axis_tdata[ELEMS_LSB +: IN_ELEMS*ELEM_W];
                    OP_LOAD_B:
                        rows_b_mem[s_axis_tdata[ROW_INDEX_LSB +: ROW_INDEX_W]] =
                            s_axis_tdata[ELEMS_LSB +: IN_ELEMS*ELEM_W];
                    OP_EVAL:
                        relation_q.push_back(predict_relation(
                            int'(s_axis_tdata[ROWS_A_LSB +: ROW_COUNT_W]),
                            int'(s_axis_tdata[ROWS_B_LSB +: ROW_COUNT_W])));
                    default:
                        ;
                endcase
            end
            fail_count <= fails;
            outstanding <= relation_q.size();
            results_seen <= seen;
        end
    end

endmodule

[dv/tb_top.sv]
module tb_top
    import rscc_pkg::*;
();

    typedef logic [IN_ELEMS-1:0][ELEM_W-1:0] row_word_t;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 380;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [OPCODE_W-1:0]  s_axis_tuser = OP_LOAD_A;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    int fail_count;
    int outstanding;
    int results_seen;

    int send_idle_pct = 28;
    int recv_idle_pct = 77;
    int phase_items;
    int load_count;
    int eval_count;
    int ignored_count;

    logic [MAX_ROWS_DEF-1:0] written_a = '0;
    logic [MAX_ROWS_DEF-1:0] written_b = '0;
    row_word_t               stim_a [MAX_ROWS_DEF];

    row_set_containment_check dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    relation_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .results_seen  (results_seen)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic row_word_t row_of(int e0, int e1, int e2, int e3);
        return {e3[31:0], e2[31:0], e1[31:0], e0[31:0]};
    endfunction

    function automatic row_word_t make_row(int style, int base, int span);
        row_word_t           row;
        logic [ELEM_W-1:0]   tmp;
        for (int e = 0; e < IN_ELEMS; e++)
        begin
            case (style)
                0: row[e] = base + $urandom_range(span);
                1: row[e] = $urandom;
                default:
                    case ($urandom_range(6))
                        0: row[e] = 32'h8000_0000;
                        1: row[e] = 32'h8000_0001;
                        2: row[e] = 32'hFFFF_FFFF;
                        3: row[e] = 32'h0000_0000;
                        4: row[e] = 32'h0000_0001;
                        5: row[e] = 32'h7FFF_FFFE;
                        default: row[e] = 32'h7FFF_FFFF;
                    endcase
            endcase
        end
        if (style != 1)
        begin
            for (int i = 0; i < IN_ELEMS - 1; i++)
                for (int j = i + 1; j < IN_ELEMS; j++)
                    if ($signed(row[i]) > $signed(row[j]))
                    begin
                        tmp = row[i];
                        row[i] = row[j];
                        row[j] = tmp;
                    end
        end
        return row;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_beat(logic [ROW_INDEX_W-1:0] idx,
                                                      row_word_t row,
                                                      logic [ROW_COUNT_W-1:0] na,
                                                      logic [ROW_COUNT_W-1:0] nb);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[ROW_INDEX_LSB +: ROW_INDEX_W] = idx;
        d[ELEMS_LSB +: IN_ELEMS*ELEM_W] = row;
        d[ROWS_A_LSB +: ROW_COUNT_W] = na;
        d[ROWS_B_LSB +: ROW_COUNT_W] = nb;
        return d;
    endfunction

    // Only a prefix of loaded rows may be named by an evaluate beat.
    function automatic int loaded_prefix(logic [MAX_ROWS_DEF-1:0] written);
        int n;
        n = 0;
        while (n < MAX_ROWS_DEF && written[n])
            n++;
        return n;
    endfunction

    function automatic int pick_count(int prefix);
        if (prefix == MAX_ROWS_DEF && $urandom_range(3) == 0)
            return $urandom_range(31, MAX_ROWS_DEF);
        return $urandom_range(prefix, 0);
    endfunction

    task automatic send_beat(input logic [OPCODE_W-1:0] op, input logic [S_TDATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (op != OP_UNUSED)
            phase_items++;
    endtask

    task automatic load_row(input logic [OPCODE_W-1:0] op, input int idx, input row_word_t row);
        send_beat(op, pack_beat(idx[ROW_INDEX_W-1:0], row, '0, '0));
        if (op == OP_LOAD_A)
        begin
            written_a[idx] = 1'b1;
            stim_a[idx] = row;
        end
        else
            written_b[idx] = 1'b1;
        load_count++;
    endtask

    task automatic evaluate(input int na, input int nb);
        row_word_t junk;
        junk = make_row(1, 0, 0);
        send_beat(OP_EVAL, pack_beat(ROW_INDEX_W'($urandom_range(15)), junk,
                                     na[ROW_COUNT_W-1:0], nb[ROW_COUNT_W-1:0]));
        eval_count++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Load both matrices row by row with related contents, then evaluate.
    task automatic run_sequence();
        int        rows_a_n;
        int        rows_b_n;
        int        style;
        int        base;
        int        span;
        int        sel;
        row_word_t row;
        rows_a_n = ($urandom_range(4) == 0) ? MAX_ROWS_DEF : $urandom_range(6, 1);
        rows_b_n = ($urandom_range(4) == 0) ? MAX_ROWS_DEF : $urandom_range(6, 1);
        sel = $urandom_range(9);
        style = (sel < 8) ? 0 : ((sel == 8) ? 1 : 2);
        base = ($urandom_range(1) == 1) ? int'($urandom_range(40)) - 20 : $urandom;
        if (base > 32'sh7FFF_0000)
            base = 32'sh7FFF_0000;
        span = ($urandom_range(1) == 1) ? 5 : 2;
        for (int r = 0; r < rows_a_n; r++)
            load_row(OP_LOAD_A, r, make_row(style, base, span));
        for (int r = 0; r < rows_b_n; r++)
        begin
            if ($urandom_range(9) < 4)
                row = stim_a[$urandom_range(loaded_prefix(written_a) - 1, 0)];
            else
                row = make_row(style, base, span);
            load_row(OP_LOAD_B, r, row);
        end
        repeat ($urandom_range(3, 1))
            evaluate(pick_count(loaded_prefix(written_a)), pick_count(loaded_prefix(written_b)));
    endtask

    // Scattered loads, ignored beats and evaluates over whatever is loaded.
    task automatic run_noise();
        logic [OPCODE_W-1:0] op;
        logic [S_TDATA_W-1:0] d;
        repeat ($urandom_range(5, 1))
        begin
            op = OPCODE_W'($urandom_range(3));
            case (op)
                OP_LOAD_A,
                OP_LOAD_B:
                    load_row(op, $urandom_range(15), make_row($urandom_range(2), 0, 3));
                OP_EVAL:
                    evaluate(pick_count(loaded_prefix(written_a)),
                             pick_count(loaded_prefix(written_b)));
                default:
                begin
                    d = '0;
                    d[S_FIELDS_W-1:0] = S_FIELDS_W'({$urandom, $urandom, $urandom, $urandom,
                                                     $urandom});
                    send_beat(OP_UNUSED, d);
                    ignored_count++;
                end
            endcase
        end
    endtask

    initial
    begin
        int pick;
        phase_items = 0;
        load_count = 0;
        eval_count = 0;
        ignored_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With no rows at all, A covers B vacuously.
        evaluate(0, 0);
        load_row(OP_LOAD_A, 0, row_of(32'h8000_0000, -1, 0, 32'h7FFF_FFFF));
        load_row(OP_LOAD_B, 0, row_of(32'h8000_0000, -1, 0, 32'h7FFF_FFFF));
        evaluate(1, 1);
        evaluate(1, 0);
        evaluate(0, 1);
        load_row(OP_LOAD_A, 1, row_of(1, 2, 3, 4));
        load_row(OP_LOAD_B, 1, row_of(5, 6, 7, 8));
        evaluate(2, 2);
        load_row(OP_LOAD_B, 2, row_of(1, 1, 2, 4));
        evaluate(2, 3);
        load_row(OP_LOAD_A, 2, row_of(1, 1, 1, 1));
        evaluate(3, 3);
        // The unused opcode must leave the rows untouched and give no result.
        send_beat(OP_UNUSED, {{(S_TDATA_W-S_FIELDS_W){1'b0}}, {S_FIELDS_W{1'b1}}});
        ignored_count++;
        evaluate(3, 1);
        load_row(OP_LOAD_A, 15, row_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                       32'h7FFF_FFFF));
        load_row(OP_LOAD_B, 15, row_of(3, 2, 1, 0));
        evaluate(1, 3);
        drain_results();

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 28;
                    recv_idle_pct = 77;
                end
                1:
                begin
                    send_idle_pct = 77;
                    recv_idle_pct = 28;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 80)
                    run_sequence();
                else
                    run_noise();
            end
            drain_results();
        end

        repeat (600) @(posedge clk);
        $display("Sent %0d load beats, %0d evaluate beats and %0d ignored beats",
                 load_count, eval_count, ignored_count);
        $display("under three idling mixes; checked %0d relation beats.", results_seen);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/rscc_pkg.sv
sv/rscc_lane.sv
sv/rscc_merge.sv
sv/row_set_containment_check.sv
dv/relation_checker.sv
dv/tb_top.sv
